### sv/ames_pkg.sv
// shared types and codes for the adjacency matrix edge store
// no dependencies; imported by every module of the block
package ames_pkg;

    localparam int CMD_W    = 3;
    localparam int VTX_W    = 6;
    localparam int WEIGHT_W = 32;
    localparam int DEGREE_W = 7;
    localparam int VCOUNT_W = 7;
    localparam int ECOUNT_W = 13;
    localparam int STATUS_W = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CMD_W-1:0] CMD_ADD_VERTEX = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK_EDGE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_EDGE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET_EDGE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IN_DEGREE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_OUT_DEGREE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_CHECK,
        OP_SET,
        OP_GET,
        OP_IN,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] status;
        logic [VTX_W-1:0]    row;
        logic [VTX_W-1:0]    column;
        logic [WEIGHT_W-1:0] weight;
    } item_t;

endpackage

### sv/ames_front.sv
// front end: accepts commands, range checks them and tracks the vertex count
// depends on ames_pkg; feeds ames_queue
module ames_front
    import ames_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [VTX_W-1:0]  row,
    input  logic [VTX_W-1:0]  column,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic              q_full,
    input  logic              clear_done,
    output logic              push,
    output item_t             item
);

    localparam int VC_W  = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (VC_W > VTX_W) ? VC_W : VTX_W;
    localparam logic [VC_W-1:0] VC_MAX = VC_W'(MAX_VERTICES);

    logic [VC_W-1:0] vc_reg;
    logic [VC_W-1:0] vc_next;
    logic            row_ok;
    logic            col_ok;
    op_t             op;
    logic [STATUS_W-1:0] status;

    assign in_ready = !q_full && clear_done;
    assign push     = in_valid && in_ready;

    assign row_ok = CMP_W'(row) < CMP_W'(vc_reg);
    assign col_ok = CMP_W'(column) < CMP_W'(vc_reg);

    always_comb
    begin
        op      = OP_NONE;
        status  = ST_OK;
        vc_next = vc_reg;
        unique case (command) inside
            CMD_ADD_VERTEX:
            begin
                if (vc_reg == VC_MAX)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op      = OP_ADD;
                    vc_next = vc_reg + 1'b1;
                end
            end
            CMD_CHECK_EDGE, CMD_SET_EDGE, CMD_GET_EDGE:
            begin
                if (row_ok && col_ok)
                begin
                    op = (command == CMD_CHECK_EDGE) ? OP_CHECK :
                         (command == CMD_SET_EDGE)   ? OP_SET : OP_GET;
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            CMD_IN_DEGREE:
            begin
                if (col_ok)
                begin
                    op = OP_IN;
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            CMD_OUT_DEGREE:
            begin
                if (row_ok)
                begin
                    op = OP_OUT;
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    assign item.op     = op;
    assign item.status = status;
    assign item.row    = row;
    assign item.column = column;
    assign item.weight = weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= '0;
        end
        else if (push)
        begin
            vc_reg <= vc_next;
        end
    end

endmodule

### sv/ames_queue.sv
// short command queue between the front end and the execution back end
// depends on ames_pkg for the queued item type
module ames_queue
    import ames_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/ames_back.sv
// back end: presence and weight memories, edge count, degree scans, result register
// depends on ames_pkg; drains ames_queue
module ames_back
    import ames_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  item_t               head,
    input  logic                q_empty,
    output logic                pop,
    output logic                clear_done,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                present,
    output logic [WEIGHT_W-1:0] weight_out,
    output logic [DEGREE_W-1:0] degree,
    output logic [VCOUNT_W-1:0] vertices,
    output logic [ECOUNT_W-1:0] edge_total,
    output logic [STATUS_W-1:0] status
);

    localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
    localparam int CELL_W = $clog2(DEPTH);
    localparam int VX_W   = $clog2(MAX_VERTICES);
    localparam int VC_W   = $clog2(MAX_VERTICES + 1);
    localparam int EC_W   = $clog2(DEPTH + 1);
    localparam logic [CELL_W-1:0] STRIDE = CELL_W'(MAX_VERTICES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic                present_mem [DEPTH];
    logic [WEIGHT_W-1:0] weight_mem  [DEPTH];

    logic [2:0]          state_reg;
    item_t               work_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [CELL_W-1:0]   clear_idx_reg;
    logic [VC_W-1:0]     scan_idx_reg;
    logic                scan_vld_reg;
    logic [VC_W-1:0]     vc_reg;
    logic [EC_W-1:0]     ec_reg;
    logic [VC_W-1:0]     deg_reg;
    logic                res_present_reg;
    logic [WEIGHT_W-1:0] res_weight_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                present_q;
    logic [WEIGHT_W-1:0] weight_q;

    logic                out_valid_reg;
    logic                out_present_reg;
    logic [WEIGHT_W-1:0] out_weight_reg;
    logic [DEGREE_W-1:0] out_degree_reg;
    logic [VCOUNT_W-1:0] out_vertices_reg;
    logic [ECOUNT_W-1:0] out_edges_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [CELL_W-1:0]   head_cell;
    logic [CELL_W-1:0]   scan_cell;
    logic [CELL_W-1:0]   rd_addr;
    logic [VX_W-1:0]     scan_vx;
    logic                pres_we;
    logic [CELL_W-1:0]   pres_waddr;
    logic                pres_wdata;
    logic                weight_we;
    logic                slot_free;

    assign head_cell = CELL_W'(VX_W'(head.row)) * STRIDE + CELL_W'(VX_W'(head.column));
    assign scan_vx   = scan_idx_reg[VX_W-1:0];
    assign scan_cell = (work_reg.op == OP_IN)
                     ? CELL_W'(scan_vx) * STRIDE + CELL_W'(VX_W'(work_reg.column))
                     : CELL_W'(VX_W'(work_reg.row)) * STRIDE + CELL_W'(scan_vx);

    assign rd_addr = (state_reg == S_IDLE) ? head_cell :
                     (state_reg == S_SCAN) ? scan_cell : cell_reg;

    assign pop        = (state_reg == S_IDLE) && !q_empty;
    assign clear_done = (state_reg != S_CLEAR);
    assign slot_free  = !out_valid_reg || out_ready;

    assign weight_we  = (state_reg == S_EXEC) && (work_reg.op == OP_SET);
    assign pres_we    = (state_reg == S_CLEAR) || weight_we;
    assign pres_waddr = (state_reg == S_CLEAR) ? clear_idx_reg : cell_reg;
    assign pres_wdata = (state_reg != S_CLEAR);

    always_ff @(posedge clk)
    begin
        if (pres_we)
        begin
            present_mem[pres_waddr] <= pres_wdata;
        end
        present_q <= present_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (weight_we)
        begin
            weight_mem[cell_reg] <= work_reg.weight;
        end
        weight_q <= weight_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clear_idx_reg   <= '0;
            scan_idx_reg    <= '0;
            scan_vld_reg    <= 1'b0;
            vc_reg          <= '0;
            ec_reg          <= '0;
            deg_reg         <= '0;
            res_present_reg <= 1'b0;
            res_status_reg  <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clear_idx_reg <= clear_idx_reg + 1'b1;
                    if (clear_idx_reg == CELL_W'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        res_present_reg <= 1'b0;
                        res_status_reg  <= head.status;
                        deg_reg         <= '0;
                        scan_idx_reg    <= '0;
                        scan_vld_reg    <= 1'b0;
                        state_reg <= (head.op == OP_IN || head.op == OP_OUT) ? S_SCAN : S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    unique case (work_reg.op)
                        OP_ADD:   vc_reg <= vc_reg + 1'b1;
                        OP_CHECK: res_present_reg <= present_q;
                        OP_SET:
                        begin
                            if (!present_q)
                            begin
                                ec_reg <= ec_reg + 1'b1;
                            end
                        end
                        OP_GET:
                        begin
                            if (present_q)
                            begin
                                res_present_reg <= 1'b1;
                            end
                            else
                            begin
                                res_status_reg <= ST_ABSENT;
                            end
                        end
                        default:
                        begin
                            res_present_reg <= 1'b0;
                        end
                    endcase
                    state_reg <= S_EMIT;
                end
                S_SCAN:
                begin
                    if (scan_vld_reg && present_q)
                    begin
                        deg_reg <= deg_reg + 1'b1;
                    end
                    if (scan_idx_reg < vc_reg)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        scan_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        scan_vld_reg <= 1'b0;
                        if (!scan_vld_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_EMIT && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= head;
            cell_reg <= head_cell;
        end
        if (state_reg == S_EXEC)
        begin
            res_weight_reg <= (work_reg.op == OP_GET && present_q) ? weight_q : '0;
        end
        else if (state_reg == S_SCAN)
        begin
            res_weight_reg <= '0;
        end
        if (state_reg == S_EMIT && slot_free)
        begin
            out_present_reg  <= res_present_reg;
            out_weight_reg   <= res_weight_reg;
            out_degree_reg   <= DEGREE_W'(deg_reg);
            out_vertices_reg <= VCOUNT_W'(vc_reg);
            out_edges_reg    <= ECOUNT_W'(ec_reg);
            out_status_reg   <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign present    = out_present_reg;
    assign weight_out = out_weight_reg;
    assign degree     = out_degree_reg;
    assign vertices   = out_vertices_reg;
    assign edge_total = out_edges_reg;
    assign status     = out_status_reg;

endmodule

### sv/adjacency_matrix_edge_store.sv
// top level of the adjacency matrix edge store: stream ports, front end, queue, back end
// depends on ames_pkg, ames_front, ames_queue and ames_back
//
// Graph edge store over a MAX_VERTICES x MAX_VERTICES matrix of 32-bit weights with a
// presence bit per entry, addressed as row * MAX_VERTICES + column. After reset the block
// clears all MAX_VERTICES * MAX_VERTICES presence entries (4096 at the default) one entry
// per cycle, with s_axis_tready low. Add vertex, check, set and get edge go through a
// memory read, an update and the result register in the back end; in-degree and
// out-degree walk one column or row entry per cycle through the single presence read
// port. A four-entry command queue lets the front end keep accepting while the back end
// works and a result waits to be taken.
module adjacency_matrix_edge_store
    import ames_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row, column, weight, zero pad
    input  logic [47:0] s_axis_tdata,
    // command
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // present, weight_out, degree, vertices, edge_total, zero pad
    output logic [63:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser
);

    item_t               push_item;
    item_t               head;
    logic                q_push;
    logic                q_pop;
    logic                q_empty;
    logic                q_full;
    logic                clear_done;
    logic                present;
    logic [WEIGHT_W-1:0] weight_out;
    logic [DEGREE_W-1:0] degree;
    logic [VCOUNT_W-1:0] vertices;
    logic [ECOUNT_W-1:0] edge_total;
    logic [STATUS_W-1:0] status;

    ames_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .command    (s_axis_tuser),
        .row        (s_axis_tdata[5:0]),
        .column     (s_axis_tdata[11:6]),
        .weight     (s_axis_tdata[43:12]),
        .q_full     (q_full),
        .clear_done (clear_done),
        .push       (q_push),
        .item       (push_item)
    );

    ames_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    ames_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (q_pop),
        .clear_done (clear_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .present    (present),
        .weight_out (weight_out),
        .degree     (degree),
        .vertices   (vertices),
        .edge_total (edge_total),
        .status     (status)
    );

    assign m_axis_tdata = {4'b0000, edge_total, vertices, degree, weight_out, present};
    assign m_axis_tuser = status;

    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("command queue underflow");

    assert property (@(posedge clk) disable iff (!rst_n) !clear_done |-> !s_axis_tready)
        else $error("command accepted during presence clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_RANGE) |-> (m_axis_tdata[39:0] == '0))
        else $error("out of range result carries data");

endmodule

### test/tb_adjacency_matrix_edge_store.sv
// testbench for adjacency_matrix_edge_store: drives graph commands over the input stream
// and checks every reply against a shadow copy of the matrix and counts kept in a class
// depends on ames_pkg and the adjacency_matrix_edge_store rtl
module tb_adjacency_matrix_edge_store;
    import ames_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_VERTICES = 64;
    localparam int CELL_COUNT   = MAX_VERTICES * MAX_VERTICES;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 100;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic                present;
        logic [WEIGHT_W-1:0] weight_out;
        logic [DEGREE_W-1:0] degree;
        logic [VCOUNT_W-1:0] vertices;
        logic [ECOUNT_W-1:0] edge_total;
        logic [STATUS_W-1:0] status;
    } reply_t;

    class graph_shadow;
        bit            present_map [0:CELL_COUNT-1];
        logic [31:0]   weight_map [0:CELL_COUNT-1];
        int            vertex_count;
        int            edge_count;
        int            live_cells[$];
        reply_t        replies[$];
        int            failures;
        int            shown;

        function new();
            foreach (present_map[i])
                present_map[i] = 1'b0;
            vertex_count = 0;
            edge_count   = 0;
            failures     = 0;
            shown        = 0;
        endfunction

        function bool_in_range(input logic [VTX_W-1:0] v);
            return int'(v) < vertex_count;
        endfunction

        function void apply_command(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] row,
                                    input logic [VTX_W-1:0] col,
                                    input logic [WEIGHT_W-1:0] w);
            reply_t r;
            int     flat_idx;
            int     count;
            r        = '0;
            flat_idx = int'(row) * MAX_VERTICES + int'(col);
            count    = 0;
            case (cmd)
                CMD_ADD_VERTEX:
                    if (vertex_count >= MAX_VERTICES)
                        r.status = ST_FULL;
                    else
                        vertex_count++;
                CMD_CHECK_EDGE:
                    if (!bool_in_range(row) || !bool_in_range(col))
                        r.status = ST_RANGE;
                    else
                        r.present = present_map[flat_idx];
                CMD_SET_EDGE:
                    if (!bool_in_range(row) || !bool_in_range(col))
                        r.status = ST_RANGE;
                    else
                    begin
                        if (!present_map[flat_idx])
                        begin
                            edge_count++;
                            live_cells = {live_cells, flat_idx};
                        end
                        present_map[flat_idx] = 1'b1;
                        weight_map[flat_idx]  = w;
                    end
                CMD_GET_EDGE:
                    if (!bool_in_range(row) || !bool_in_range(col))
                        r.status = ST_RANGE;
                    else if (present_map[flat_idx])
                    begin
                        r.present    = 1'b1;
                        r.weight_out = weight_map[flat_idx];
                    end
                    else
                        r.status = ST_ABSENT;
                CMD_IN_DEGREE:
                    if (!bool_in_range(col))
                        r.status = ST_RANGE;
                    else
                    begin
                        for (int i = 0; i < vertex_count; i++)
                            if (present_map[i * MAX_VERTICES + int'(col)])
                                count++;
                        r.degree = DEGREE_W'(count);
                    end
                CMD_OUT_DEGREE:
                    if (!bool_in_range(row))
                        r.status = ST_RANGE;
                    else
                    begin
                        for (int i = 0; i < vertex_count; i++)
                            if (present_map[int'(row) * MAX_VERTICES + i])
                                count++;
                        r.degree = DEGREE_W'(count);
                    end
                default:
                    ;
            endcase
            r.vertices   = VCOUNT_W'(vertex_count);
            r.edge_total = ECOUNT_W'(edge_count);
            replies = {replies, r};
        endfunction

        function void check_reply(input logic [63:0] data, input logic [STATUS_W-1:0] status);
            reply_t got;
            reply_t want;
            got.present    = data[0];
            got.weight_out = data[32:1];
            got.degree     = data[39:33];
            got.vertices   = data[46:40];
            got.edge_total = data[59:47];
            got.status     = status;
            if (replies.size() == 0)
            begin
                failures++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected reply: present=%0d weight=%0h degree=%0d vertices=%0d edges=%0d status=%0d",
                             got.present, got.weight_out, got.degree, got.vertices,
                             got.edge_total, got.status);
                end
                return;
            end
            want = replies.pop_front();
            if (got.present !== want.present || got.weight_out !== want.weight_out ||
                got.degree !== want.degree || got.vertices !== want.vertices ||
                got.edge_total !== want.edge_total || got.status !== want.status)
            begin
                failures++;
                if (shown < 10)
                begin
                    shown++;
                    $display("reply mismatch: expected present=%0d weight=%0h degree=%0d vertices=%0d edges=%0d status=%0d",
                             want.present, want.weight_out, want.degree, want.vertices,
                             want.edge_total, want.status);
                    $display("                actual   present=%0d weight=%0h degree=%0d vertices=%0d edges=%0d status=%0d",
                             got.present, got.weight_out, got.degree, got.vertices,
                             got.edge_total, got.status);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    graph_shadow board = new();
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;

    adjacency_matrix_edge_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver side: random stalls, plus a long hold-off counted here
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_reply(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("adjacency_matrix_edge_store test failed");
        $finish;
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] row,
                                input logic [VTX_W-1:0] col, input logic [WEIGHT_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, w, col, row};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.apply_command(cmd, row, col, w);
    endtask

    initial
    begin
        logic [CMD_W-1:0]    cmd;
        logic [VTX_W-1:0]    row;
        logic [VTX_W-1:0]    col;
        logic [WEIGHT_W-1:0] w;
        int                  add_pct;
        int                  pick;
        int                  flat_idx;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty graph, weight extremes, repeats, absent and fresh entries, spare codes
        send_command(CMD_CHECK_EDGE, 6'd0, 6'd0, 32'h0);
        send_command(CMD_OUT_DEGREE, 6'd0, 6'd0, 32'h0);
        send_command(CMD_ADD_VERTEX, 6'd0, 6'd0, 32'h0);
        send_command(CMD_ADD_VERTEX, 6'd63, 6'd63, 32'hffff_ffff);
        send_command(CMD_ADD_VERTEX, 6'd0, 6'd0, 32'h0);
        send_command(CMD_SET_EDGE, 6'd0, 6'd1, 32'h0);
        send_command(CMD_SET_EDGE, 6'd0, 6'd1, 32'hffff_ffff);
        send_command(CMD_GET_EDGE, 6'd0, 6'd1, 32'h0);
        send_command(CMD_GET_EDGE, 6'd1, 6'd0, 32'h0);
        send_command(CMD_CHECK_EDGE, 6'd0, 6'd1, 32'h0);
        send_command(CMD_CHECK_EDGE, 6'd1, 6'd0, 32'h0);
        send_command(CMD_SET_EDGE, 6'd2, 6'd2, 32'ha5a5_a5a5);
        send_command(CMD_SET_EDGE, 6'd2, 6'd1, 32'h1234_5678);
        send_command(CMD_IN_DEGREE, 6'd0, 6'd1, 32'h0);
        send_command(CMD_OUT_DEGREE, 6'd2, 6'd0, 32'h0);
        send_command(CMD_SET_EDGE, 6'd3, 6'd0, 32'h5a5a_5a5a);
        send_command(CMD_GET_EDGE, 6'd63, 6'd63, 32'h0);
        send_command(CMD_CHECK_EDGE, 6'd0, 6'd63, 32'h0);
        send_command(CMD_IN_DEGREE, 6'd0, 6'd63, 32'h0);
        send_command(CMD_SPARE_A, 6'd63, 6'd63, 32'hffff_ffff);
        send_command(CMD_SPARE_B, 6'd1, 6'd1, 32'h1);
        send_command(CMD_ADD_VERTEX, 6'd0, 6'd0, 32'h0);
        send_command(CMD_GET_EDGE, 6'd3, 6'd1, 32'h0);
        send_command(CMD_OUT_DEGREE, 6'd3, 6'd0, 32'h0);
        send_command(CMD_IN_DEGREE, 6'd0, 6'd3, 32'h0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 0 && k == 20)
                    hold_left = HOLD_CYCLES;
                add_pct = (board.vertex_count < MAX_VERTICES) ? 25 : 4;
                pick    = $urandom_range(0, 99);
                w       = $urandom;
                row     = VTX_W'($urandom_range(0, 63));
                col     = VTX_W'($urandom_range(0, 63));
                if ($urandom_range(0, 99) < 88 && board.vertex_count > 0)
                begin
                    row = VTX_W'($urandom_range(0, board.vertex_count - 1));
                    col = VTX_W'($urandom_range(0, board.vertex_count - 1));
                    if ($urandom_range(0, 3) == 0)
                        col = 6'd0;
                end
                if ($urandom_range(0, 99) < add_pct)
                    cmd = CMD_ADD_VERTEX;
                else if (pick < 30)
                    cmd = CMD_SET_EDGE;
                else if (pick < 45)
                    cmd = CMD_CHECK_EDGE;
                else if (pick < 70)
                    cmd = CMD_GET_EDGE;
                else if (pick < 82)
                    cmd = CMD_IN_DEGREE;
                else if (pick < 94)
                    cmd = CMD_OUT_DEGREE;
                else
                    cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
                // reads of existing edges half the time
                if ((cmd == CMD_GET_EDGE || cmd == CMD_CHECK_EDGE) &&
                    board.live_cells.size() > 0 && $urandom_range(0, 1) == 1)
                begin
                    flat_idx = board.live_cells[$urandom_range(0, board.live_cells.size() - 1)];
                    row      = VTX_W'(flat_idx / MAX_VERTICES);
                    col      = VTX_W'(flat_idx % MAX_VERTICES);
                end
                send_command(cmd, row, col, w);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (board.failures == 0 && board.replies.size() == 0)
            $display("adjacency_matrix_edge_store test passed");
        else
            $display("adjacency_matrix_edge_store test failed");
        $finish;
    end

endmodule
